// ===== rtl/sdx_pkg.sv =====
`timescale 1ns / 1ps
package sdx_pkg;

  localparam int unsigned MAX_NEST = 255;
  // Both nesting counters are 8 bits wide, so the usable limit saturates at 255.
  localparam logic [7:0] NestLimit = (MAX_NEST > 255) ? 8'd255 : 8'(MAX_NEST);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    M_IDLE,
    M_START,
    M_LIST,
    M_LINECOM,
    M_COMMA,
    M_HASH,
    M_CHAR,
    M_TOKEN,
    M_WEIRD,
    M_WEIRD_ESC,
    M_WEIRD_BRACE,
    M_STR,
    M_STR_ESC,
    M_COM,
    M_COM_BAR,
    M_COM_HASH
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE               = 3'd0,
    ERR_MISSING_CLOSE      = 3'd1,
    ERR_UNEXPECTED_CLOSE   = 3'd2,
    ERR_UNBALANCED_COMMENT = 3'd3,
    ERR_OPEN_STRING        = 3'd4,
    ERR_OVERFLOW           = 3'd5
  } err_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] ldepth;
    logic [7:0] cdepth;
  } state_t;

  typedef struct packed {
    logic       consumed;
    logic       done_res;
    err_e       error_code;
    logic [7:0] depth;
  } result_t;

  localparam state_t StateReset = '{mode: M_IDLE, ldepth: 8'd0, cdepth: 8'd0};

endpackage

// ===== rtl/sdx_in_if.sv =====
`timescale 1ns / 1ps
interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ===== rtl/sdx_out_if.sv =====
`timescale 1ns / 1ps
interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic       consumed;
  logic       done_res;
  logic [2:0] error_code;
  logic [7:0] depth;

  modport source (output valid, output consumed, output done_res, output error_code,
                  output depth, input ready);
  modport sink (input valid, input consumed, input done_res, input error_code,
                input depth, output ready);
endinterface

// ===== rtl/sdx_step.sv =====
`timescale 1ns / 1ps
module sdx_step (
  input  sdx_pkg::state_t  state_i,
  input  logic [7:0]       ch_i,
  output sdx_pkg::state_t  state_o,
  output sdx_pkg::result_t result_o
);
  import sdx_pkg::*;

  typedef struct packed {
    state_t st;
    logic   cons;
    logic   done;
    err_e   err;
    logic   again;
  } pass_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_FF) || (c == CH_LF);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_DQUOTE) || (c == CH_SEMI) || is_space(c);
  endfunction

  // One dispatch of the character in the current mode. Sets again when the
  // same character must be handled once more in the new mode.
  function automatic pass_t scan_pass(input pass_t s, input logic [7:0] c);
    pass_t r;
    logic  end_take;
    logic  end_skip;
    r        = s;
    r.again  = 1'b0;
    end_take = 1'b0;
    end_skip = 1'b0;
    case (s.st.mode)
      M_IDLE: begin
        if (c != CH_SPACE) begin
          r.st.mode = M_START;
          r.again   = 1'b1;
        end
      end
      M_START: begin
        if (c == CH_NUL) begin
          end_skip = 1'b1;
        end else if (c inside {CH_LPAREN, CH_LBRACK}) begin
          if (s.st.ldepth >= NestLimit) begin
            r.err = ERR_OVERFLOW;
          end else begin
            r.st.ldepth = s.st.ldepth + 8'd1;
            r.cons      = 1'b1;
            r.st.mode   = M_LIST;
          end
        end else if (c inside {CH_RPAREN, CH_RBRACK}) begin
          r.err = ERR_UNEXPECTED_CLOSE;
        end else if (c inside {CH_QUOTE, CH_BQUOTE}) begin
          r.cons = 1'b1;
        end else if (c == CH_COMMA) begin
          r.cons    = 1'b1;
          r.st.mode = M_COMMA;
        end else if (c == CH_HASH) begin
          r.cons    = 1'b1;
          r.st.mode = M_HASH;
        end else if (c == CH_DQUOTE) begin
          r.cons    = 1'b1;
          r.st.mode = M_STR;
        end else begin
          r.cons    = 1'b1;
          r.st.mode = M_TOKEN;
        end
      end
      M_COMMA: begin
        r.st.mode = M_START;
        if (c == CH_AT) begin
          r.cons = 1'b1;
        end else begin
          r.again = 1'b1;
        end
      end
      M_HASH: begin
        case (c) inside
          CH_NUL: begin
            end_skip = 1'b1;
          end
          CH_LPAREN, CH_LBRACK: begin
            if (s.st.ldepth >= NestLimit) begin
              r.err = ERR_OVERFLOW;
            end else begin
              r.st.ldepth = s.st.ldepth + 8'd1;
              r.cons      = 1'b1;
              r.st.mode   = M_LIST;
            end
          end
          "t", "T", "f", "F": begin
            r.cons   = 1'b1;
            end_take = 1'b1;
          end
          "b", "B", "o", "O", "d", "D", "x", "X", "i", "I", "e", "E", CH_STAR: begin
            r.cons    = 1'b1;
            r.st.mode = M_TOKEN;
          end
          CH_LBRACE: begin
            r.cons    = 1'b1;
            r.st.mode = M_WEIRD;
          end
          CH_BSLASH: begin
            r.cons    = 1'b1;
            r.st.mode = M_CHAR;
          end
          CH_BAR: begin
            r.cons      = 1'b1;
            r.st.cdepth = 8'd1;
            r.st.mode   = M_COM;
          end
          default: begin
            r.cons    = 1'b1;
            r.st.mode = M_START;
          end
        endcase
      end
      M_CHAR: begin
        if (c == CH_NUL) begin
          end_skip = 1'b1;
        end else begin
          r.cons    = 1'b1;
          r.st.mode = M_TOKEN;
        end
      end
      M_TOKEN: begin
        if (is_delim(c)) begin
          end_skip = 1'b1;
        end else begin
          r.cons = 1'b1;
        end
      end
      M_WEIRD: begin
        if (c == CH_NUL) begin
          end_skip = 1'b1;
        end else begin
          r.cons = 1'b1;
          if (c == CH_BSLASH) begin
            r.st.mode = M_WEIRD_ESC;
          end else if (c == CH_RBRACE) begin
            r.st.mode = M_WEIRD_BRACE;
          end
        end
      end
      M_WEIRD_ESC: begin
        if (c == CH_NUL) begin
          end_skip = 1'b1;
        end else begin
          r.cons    = 1'b1;
          r.st.mode = M_WEIRD;
        end
      end
      M_WEIRD_BRACE: begin
        if (c == CH_HASH) begin
          r.cons   = 1'b1;
          end_take = 1'b1;
        end else begin
          r.st.mode = M_WEIRD;
          r.again   = 1'b1;
        end
      end
      M_STR: begin
        if (c == CH_NUL) begin
          r.err = ERR_OPEN_STRING;
        end else begin
          r.cons = 1'b1;
          if (c == CH_DQUOTE) begin
            end_take = 1'b1;
          end else if (c == CH_BSLASH) begin
            r.st.mode = M_STR_ESC;
          end
        end
      end
      M_STR_ESC: begin
        if (c == CH_NUL) begin
          r.err = ERR_OPEN_STRING;
        end else begin
          r.cons    = 1'b1;
          r.st.mode = M_STR;
        end
      end
      M_COM: begin
        if (c == CH_NUL) begin
          r.err = ERR_UNBALANCED_COMMENT;
        end else begin
          r.cons = 1'b1;
          if (c == CH_BAR) begin
            r.st.mode = M_COM_BAR;
          end else if (c == CH_HASH) begin
            r.st.mode = M_COM_HASH;
          end
        end
      end
      M_COM_BAR: begin
        if (c == CH_HASH) begin
          r.cons = 1'b1;
          if (s.st.cdepth != 8'd0) begin
            r.st.cdepth = s.st.cdepth - 8'd1;
          end
          r.st.mode = (r.st.cdepth == 8'd0) ? M_START : M_COM;
        end else begin
          r.st.mode = M_COM;
          r.again   = 1'b1;
        end
      end
      M_COM_HASH: begin
        if (c == CH_BAR) begin
          if (s.st.cdepth >= NestLimit) begin
            r.err = ERR_OVERFLOW;
          end else begin
            r.st.cdepth = s.st.cdepth + 8'd1;
            r.cons      = 1'b1;
            r.st.mode   = M_COM;
          end
        end else begin
          r.st.mode = M_COM;
          r.again   = 1'b1;
        end
      end
      M_LIST: begin
        if (c == CH_NUL) begin
          r.err = ERR_MISSING_CLOSE;
        end else if (c == CH_SEMI) begin
          r.cons    = 1'b1;
          r.st.mode = M_LINECOM;
        end else if (is_space(c)) begin
          r.cons = 1'b1;
        end else if (c inside {CH_RPAREN, CH_RBRACK}) begin
          r.cons = 1'b1;
          if (s.st.ldepth != 8'd0) begin
            r.st.ldepth = s.st.ldepth - 8'd1;
          end
          if (r.st.ldepth == 8'd0) begin
            r.done = 1'b1;
          end
        end else begin
          r.st.mode = M_START;
          r.again   = 1'b1;
        end
      end
      M_LINECOM: begin
        if (c == CH_NUL) begin
          r.err = ERR_MISSING_CLOSE;
        end else begin
          r.cons = 1'b1;
          if (c == CH_LF) begin
            r.st.mode = M_LIST;
          end
        end
      end
      default: begin
        r.st.mode = M_IDLE;
        r.again   = 1'b1;
      end
    endcase
    // A finished datum either ends the scan or returns to the enclosing list.
    if (end_take || end_skip) begin
      if (r.st.ldepth == 8'd0) begin
        r.done = 1'b1;
      end else begin
        r.st.mode = M_LIST;
        if (end_skip) begin
          r.again = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic more(input pass_t p);
    return p.again && (p.err == ERR_NONE) && !p.done;
  endfunction

  pass_t p0, p1, p2, p3;
  logic  stop;

  // Longest redispatch chain is three passes, e.g. a token ending before the
  // character, the list passing it back to start, then start handling it.
  always_comb begin
    p0    = '{st: state_i, cons: 1'b0, done: 1'b0, err: ERR_NONE, again: 1'b1};
    p1    = scan_pass(p0, ch_i);
    p2    = more(p1) ? scan_pass(p1, ch_i) : p1;
    p3    = more(p2) ? scan_pass(p2, ch_i) : p2;
    stop  = (p3.err != ERR_NONE) || p3.done;
    state_o = stop ? StateReset : p3.st;
    result_o.consumed   = p3.cons && (p3.err == ERR_NONE);
    result_o.done_res   = p3.done && (p3.err == ERR_NONE);
    result_o.error_code = p3.err;
    result_o.depth      = stop ? 8'd0 : p3.st.ldepth;
  end

endmodule

// ===== rtl/sexpr_datum_extent_scanner.sv =====
`timescale 1ns / 1ps
// Scans a character stream one character per clock and reports, for every
// character, whether it belongs to the current Scheme datum, whether the datum
// ends there, the list depth after it and any error code. An accepted character
// sits in the input register until the output register is free, and its result
// is then loaded into the output register and offered from there; the step logic
// between those registers is combinational and also updates the scan mode and
// the list and comment depth counters; it sustains one character per cycle as
// long as results are taken. After a done or an error the scanner is back to
// skipping leading spaces for the next datum.
module sexpr_datum_extent_scanner (
  input logic      clk_i,
  input logic      rst_ni,
  sdx_in_if.sink   in_i,
  sdx_out_if.source out_o
);
  import sdx_pkg::*;

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       out_valid_q;
  logic       advance;
  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  result_t    res_q;

  // Move the held character into the result stage when that stage is free.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  sdx_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.consumed   = res_q.consumed;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.error_code = res_q.error_code;
  assign out_o.depth      = res_q.depth;

  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.error_code != ERR_NONE)) |->
      (!res_q.consumed && !res_q.done_res && (res_q.depth == 8'd0)))
    else $error("error result carries datum flags or depth");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.done_res || (res_d.error_code != ERR_NONE))) |=>
      (state_q == StateReset))
    else $error("scanner did not restart after done or error");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("scan state changed without a character");

  a_depth_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.ldepth <= NestLimit) && (state_q.cdepth <= NestLimit))
    else $error("nesting depth beyond limit");

  a_comment_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.cdepth != 8'd0) |->
      ((state_q.mode == M_COM) || (state_q.mode == M_COM_BAR) ||
       (state_q.mode == M_COM_HASH)))
    else $error("comment depth held outside a block comment");

endmodule
